// ----- rtl/core/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants and controller/datapath interface types for the bitmap
// block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int REG_W     = 13;
	localparam int BLK_W     = 12;
	localparam int ST_W      = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USABLE = 1'b1;

	localparam logic [REG_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;
	localparam logic [REG_W-1:0] FIRST_USABLE_RST = 13'd0;

	typedef struct packed {
		logic clr_step;   // zero one bitmap word, advance clear pointer
		logic scan_init;  // load scan pointer with first usable word
		logic scan_rd;    // issue next scan read
		logic scan_eval;  // evaluate returned word, commit on hit
		logic free_rd;    // read word holding the block to free
		logic free_wr;    // write word back with the bit cleared
		logic res_full;   // emit no-free-block result
		logic res_range;  // emit out-of-range result
	} bba_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic alloc_empty;
		logic free_range;
		logic hit;
		logic scan_end;
	} bba_stat_t;

endpackage

// ----- rtl/core/bba_ctrl.sv -----
// ----------------------------------------------------------------------------
// bba_ctrl
// Controller: runs the post-reset clear sweep, dispatches allocate and free
// requests and steps the datapath through the bitmap scan.
// ----------------------------------------------------------------------------
module bba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               req_type,
	input  bba_pkg::bba_stat_t stat,
	output bba_pkg::bba_cmd_t  cmd,
	output logic               busy
);
	import bba_pkg::*;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_FREE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					if (req_type == REQ_ALLOC) begin
						if (stat.alloc_empty) begin
							cmd.res_full = 1'b1;
						end else begin
							cmd.scan_init = 1'b1;
							state_nxt     = S_SCAN;
						end
					end else begin
						if (stat.free_range) begin
							cmd.res_range = 1'b1;
						end else begin
							cmd.free_rd = 1'b1;
							state_nxt   = S_FREE;
						end
					end
				end
			end
			S_SCAN: begin
				cmd.scan_rd   = 1'b1;
				cmd.scan_eval = 1'b1;
				if (stat.hit) begin
					state_nxt = S_IDLE;
				end else if (stat.scan_end) begin
					cmd.res_full = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_FREE: begin
				cmd.free_wr = 1'b1;
				state_nxt   = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- rtl/core/bba_datapath.sv -----
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap memory, clear sweep pointer, pipelined word scan with first-usable /
// total masking and priority encode, free read-modify-write, result register.
// ----------------------------------------------------------------------------
module bba_datapath #(
	parameter int MAX_BLOCKS = 4096,
	parameter int WORD_BITS  = 32   // power of two
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [bba_pkg::REG_W-1:0]  total_blocks,
	input  logic [bba_pkg::REG_W-1:0]  first_usable,
	input  logic [bba_pkg::BLK_W-1:0]  block_number,
	input  bba_pkg::bba_cmd_t          cmd,
	output bba_pkg::bba_stat_t         stat,
	output logic                       done,
	output logic [bba_pkg::BLK_W-1:0]  alloc_block,
	output logic [bba_pkg::ST_W-1:0]   status
);
	import bba_pkg::*;

	localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int OFF_W     = $clog2(WORD_BITS);
	localparam int CNT_W     = ($clog2(MAX_BLOCKS + 1) > REG_W) ?
	                           $clog2(MAX_BLOCKS + 1) : REG_W;
	localparam int NB_W      = AW + OFF_W;

	localparam logic [CNT_W-1:0] MAX_C     = CNT_W'(MAX_BLOCKS);
	localparam logic [AW-1:0]    LAST_ADDR = AW'(NUM_WORDS - 1);
	localparam logic [OFF_W-1:0] TOP_BIT   = OFF_W'(WORD_BITS - 1);

	logic [WORD_BITS-1:0] mem [NUM_WORDS];

	logic [CNT_W-1:0]     tot_ext, eff_tot, tot_m1, fu_ext, blk_ext;
	logic [AW-1:0]        last_w, fu_w, blk_w;
	logic [OFF_W-1:0]     last_off, fu_off;

	logic [AW-1:0]        clr_q;
	logic [AW:0]          rd_w_q;
	logic                 v_s1;
	logic [AW-1:0]        w_s1;
	logic [WORD_BITS-1:0] rdata_s1;
	logic [AW-1:0]        blk_w_q;
	logic [OFF_W-1:0]     blk_off_q;

	logic                 issue, rd_en, commit, any_free;
	logic [AW-1:0]        rd_addr;
	logic [WORD_BITS-1:0] lo_mask, hi_mask, free_bits, set_mask, clr_mask;
	logic [OFF_W-1:0]     idx;
	logic [NB_W-1:0]      hit_blk;

	logic                 done_q;
	logic [BLK_W-1:0]     alloc_q;
	logic [ST_W-1:0]      status_q;

	// effective range and word/offset split
	assign tot_ext  = CNT_W'(total_blocks);
	assign eff_tot  = (tot_ext > MAX_C) ? MAX_C : tot_ext;
	assign tot_m1   = eff_tot - CNT_W'(1);
	assign fu_ext   = CNT_W'(first_usable);
	assign blk_ext  = CNT_W'(block_number);
	assign last_w   = AW'(tot_m1 >> OFF_W);
	assign last_off = tot_m1[OFF_W-1:0];
	assign fu_w     = AW'(fu_ext >> OFF_W);
	assign fu_off   = fu_ext[OFF_W-1:0];
	assign blk_w    = AW'(blk_ext >> OFF_W);

	assign issue   = cmd.scan_rd && (rd_w_q <= {1'b0, last_w});
	assign rd_en   = issue || cmd.free_rd;
	assign rd_addr = cmd.free_rd ? blk_w : rd_w_q[AW-1:0];

	// only bits in [first_usable, total) of the returned word are candidates
	assign lo_mask   = (w_s1 == fu_w)   ? ({WORD_BITS{1'b1}} << fu_off) : '1;
	assign hi_mask   = (w_s1 == last_w) ? ({WORD_BITS{1'b1}} >> (TOP_BIT - last_off)) : '1;
	assign free_bits = ~rdata_s1 & lo_mask & hi_mask;

	always_comb begin
		any_free = 1'b0;
		idx      = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				any_free = 1'b1;
				idx      = OFF_W'(i);
			end
		end
	end

	assign commit   = cmd.scan_eval && v_s1 && any_free;
	assign set_mask = WORD_BITS'(1) << idx;
	assign clr_mask = WORD_BITS'(1) << blk_off_q;
	assign hit_blk  = {w_s1, idx};

	assign stat.clr_last    = (clr_q == LAST_ADDR);
	assign stat.alloc_empty = (fu_ext >= eff_tot);
	assign stat.free_range  = (blk_ext >= eff_tot);
	assign stat.hit         = v_s1 && any_free;
	assign stat.scan_end    = v_s1 && !any_free && (w_s1 == last_w);

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			mem[clr_q] <= '0;
		end else if (commit) begin
			mem[w_s1] <= rdata_s1 | set_mask;
		end else if (cmd.free_wr) begin
			mem[blk_w_q] <= rdata_s1 & ~clr_mask;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			rd_w_q <= '0;
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.scan_init) begin
				rd_w_q <= {1'b0, fu_w};
			end else if (issue) begin
				rd_w_q <= rd_w_q + (AW+1)'(1);
			end
			v_s1   <= issue && !cmd.scan_init;
			done_q <= commit || cmd.res_full || cmd.res_range || cmd.free_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			w_s1 <= rd_w_q[AW-1:0];
		end
		if (cmd.free_rd) begin
			blk_w_q   <= blk_w;
			blk_off_q <= blk_ext[OFF_W-1:0];
		end
		alloc_q <= commit ? BLK_W'(hit_blk) : '0;
		if (cmd.res_range) begin
			status_q <= ST_RANGE;
		end else if (cmd.res_full) begin
			status_q <= ST_FULL;
		end else begin
			status_q <= ST_OK;
		end
	end

	assign done        = done_q;
	assign alloc_block = alloc_q;
	assign status      = status_q;

endmodule

// ----- rtl/core/bitmap_block_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a used/free bitmap with one bit per block.
// A free reads the word holding the block and writes it back with the bit
// cleared; an out-of-range free or an empty range is answered from idle; an
// allocate scans from the first usable word, reading one bitmap word per cycle
// from the single memory read port. After reset, busy stays high while the
// bitmap is cleared; results are strobed on done and cannot be stalled.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
	parameter int MAX_BLOCKS = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [bba_pkg::BLK_W-1:0]     block_number,
	output logic                          done,
	output logic [bba_pkg::BLK_W-1:0]     alloc_block,
	output logic [bba_pkg::ST_W-1:0]      status,
	input  logic                          cfg_we,
	input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bba_pkg::REG_W-1:0]     cfg_data
);
	import bba_pkg::*;

	logic [REG_W-1:0] total_blocks_q;
	logic [REG_W-1:0] first_usable_q;
	bba_cmd_t         cmd;
	bba_stat_t        stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_blocks_q <= TOTAL_BLOCKS_RST;
			first_usable_q <= FIRST_USABLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOTAL_BLOCKS: total_blocks_q <= cfg_data;
				CFG_FIRST_USABLE: first_usable_q <= cfg_data;
			endcase
		end
	end

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	bba_datapath #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.WORD_BITS  (WORD_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.total_blocks (total_blocks_q),
		.first_usable (first_usable_q),
		.block_number (block_number),
		.cmd          (cmd),
		.stat         (stat),
		.done         (done),
		.alloc_block  (alloc_block),
		.status       (status)
	);

endmodule

// ----- rtl/core/bba_checker.sv -----
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the allocator's request/result behavior over time.
// ----------------------------------------------------------------------------
module bba_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      req_type,
	input logic                      done,
	input logic [bba_pkg::BLK_W-1:0] alloc_block,
	input logic [bba_pkg::ST_W-1:0]  status
);
	import bba_pkg::*;

	// an accepted beat either answers next cycle or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted request neither answered nor busy");

	// a result only follows an accepted beat or busy work
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result with no request in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_FULL || status == ST_RANGE))
		else $error("reserved status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (alloc_block == '0))
		else $error("failed request returned a block number");

	// range errors are answered right after a free request is taken
	a_range_free: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_RANGE) |->
			($past(start) && !$past(busy) && $past(req_type) == REQ_FREE))
		else $error("range status without a free request");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.req_type    (req_type),
	.done        (done),
	.alloc_block (alloc_block),
	.status      (status)
);
